// File: src/c2rb_pkg.sv
// Shared constants, codes, types and helpers of the replicate-border 2D convolution block.
package c2rb_pkg;

    // Kernel and frame geometry.
    localparam int KERNEL_SIZE = 5;
    localparam int MAX_WIDTH   = 4096;
    localparam int MAX_HEIGHT  = 4096;
    localparam int HALF        = KERNEL_SIZE / 2;
    localparam int LINE_ROWS   = KERNEL_SIZE + 1;
    localparam int TAPS        = KERNEL_SIZE * KERNEL_SIZE;

    // Field and internal widths.
    localparam int KIND_W    = 2;
    localparam int CIDX_W    = 5;
    localparam int COEF_W    = 16;
    localparam int PIX_W     = 16;
    localparam int DIM_W     = 13;
    localparam int CFG_IDX_W = 2;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = $clog2(MAX_HEIGHT);
    localparam int SLOT_W    = $clog2(LINE_ROWS);
    localparam int STEP_W    = $clog2(HALF + 1);
    localparam int PROD_W    = PIX_W + COEF_W;
    localparam int ROWSUM_W  = PROD_W + $clog2(KERNEL_SIZE);
    localparam int ACC_W     = PROD_W + $clog2(TAPS);
    localparam int RES_W     = 36;
    localparam int POS_W     = 12;

    // Command queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Item kinds.
    localparam logic [KIND_W-1:0] KIND_COEF  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PIXEL = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DRAIN = 2'd2;

    // Register indexes and reset values.
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [DIM_W-1:0]     RESET_WIDTH  = 13'd640;
    localparam logic [DIM_W-1:0]     RESET_HEIGHT = 13'd480;

    typedef logic [SLOT_W-1:0] slot_t;

    // Effective frame size, each minus one.
    typedef struct packed {
        logic [COL_W-1:0] wm1;
        logic [ROW_W-1:0] hm1;
    } geom_t;

    // One command for the back end: optional pixel store, coefficient load or output.
    typedef struct packed {
        logic                       wr_en;
        slot_t                      wr_slot;
        logic [COL_W-1:0]           wr_col;
        logic signed [PIX_W-1:0]    pixel;
        logic                       coef_en;
        logic [CIDX_W-1:0]          coef_idx;
        logic signed [COEF_W-1:0]   coef_val;
        logic                       emit;
        logic [ROW_W-1:0]           row;
        logic [COL_W-1:0]           col;
        logic                       last;
        slot_t [KERNEL_SIZE-1:0]    sel;
    } job_t;

    // Adds a small signed offset to a line slot, wrapping once around the ring.
    function automatic slot_t slot_wrap(input slot_t base, input int ofs);
        int s;
        s = int'(base) + ofs;
        if (s < 0) begin
            s = s + LINE_ROWS;
        end
        else if (s >= LINE_ROWS) begin
            s = s - LINE_ROWS;
        end
        return slot_t'(s);
    endfunction

endpackage

// File: src/c2rb_ifs.sv
// Handshake interfaces for the input items, the results and the register writes.
interface c2rb_in_if;
    import c2rb_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [KIND_W-1:0]        kind;
    logic [CIDX_W-1:0]        coef_index;
    logic signed [COEF_W-1:0] coef_value;
    logic signed [PIX_W-1:0]  pixel;
    modport source (output valid, kind, coef_index, coef_value, pixel, input ready);
    modport sink (input valid, kind, coef_index, coef_value, pixel, output ready);
endinterface

interface c2rb_out_if;
    import c2rb_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [RES_W-1:0] result;
    logic [POS_W-1:0]        out_row;
    logic [POS_W-1:0]        out_col;
    logic                    frame_last;
    modport source (output valid, result, out_row, out_col, frame_last, input ready);
    modport sink (input valid, result, out_row, out_col, frame_last, output ready);
endinterface

interface c2rb_cfg_if;
    import c2rb_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DIM_W-1:0]     data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// File: src/c2rb_front.sv
// Front end: takes items and register writes, tracks frame positions and issues commands.
module c2rb_front (
    input  logic            clk,
    input  logic            rst_n,
    c2rb_in_if.sink         item,
    c2rb_cfg_if.sink        cfg,
    output logic            push_valid,
    output c2rb_pkg::job_t  push_job,
    input  logic            push_ready,
    output c2rb_pkg::geom_t geom
);
    import c2rb_pkg::*;

    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic [ROW_W-1:0] in_row_reg, in_row_next;
    logic [COL_W-1:0] in_col_reg, in_col_next;
    slot_t            in_slot_reg, in_slot_next;
    logic             done_reg, done_next;
    logic [ROW_W-1:0] emit_row_reg, emit_row_next;
    logic [COL_W-1:0] emit_col_reg, emit_col_next;
    slot_t            emit_slot_reg, emit_slot_next;

    logic             accept;
    logic             cfg_hit;
    logic             store;
    logic             try_out;
    logic             out_ready;
    logic             emit;
    logic             last;
    logic [ROW_W:0]   er_ext;
    logic [COL_W:0]   ec_ext;
    logic [ROW_W-1:0] rr;
    logic [COL_W-1:0] cc;
    slot_t [KERNEL_SIZE-1:0] sel;

    // Effective frame size: zero acts as one, oversize saturates.
    always_comb
    begin
        if (width_reg == '0)
            geom.wm1 = '0;
        else if (width_reg > DIM_W'(MAX_WIDTH))
            geom.wm1 = COL_W'(MAX_WIDTH - 1);
        else
            geom.wm1 = COL_W'(width_reg - 1'b1);
        if (height_reg == '0)
            geom.hm1 = '0;
        else if (height_reg > DIM_W'(MAX_HEIGHT))
            geom.hm1 = ROW_W'(MAX_HEIGHT - 1);
        else
            geom.hm1 = ROW_W'(height_reg - 1'b1);
    end

    assign cfg.ready  = 1'b1;
    assign cfg_hit    = cfg.valid && (cfg.index == REG_WIDTH || cfg.index == REG_HEIGHT);
    assign item.ready = push_ready;
    assign accept     = item.valid && push_ready;
    assign store      = (item.kind == KIND_PIXEL) && !done_reg;
    assign try_out    = (item.kind == KIND_PIXEL) || (item.kind == KIND_DRAIN);

    // Input position after this item's pixel is stored.
    always_comb
    begin
        in_row_next  = in_row_reg;
        in_col_next  = in_col_reg;
        in_slot_next = in_slot_reg;
        done_next    = done_reg;
        if (store)
        begin
            if (in_col_reg == geom.wm1)
            begin
                in_col_next = '0;
                if (in_row_reg == geom.hm1)
                begin
                    done_next = 1'b1;
                end
                else
                begin
                    in_row_next  = in_row_reg + 1'b1;
                    in_slot_next = slot_wrap(in_slot_reg, 1);
                end
            end
            else
            begin
                in_col_next = in_col_reg + 1'b1;
            end
        end
    end

    // The next output is ready once its clamped bottom-right tap has arrived.
    assign er_ext = {1'b0, emit_row_reg} + (ROW_W + 1)'(HALF);
    assign ec_ext = {1'b0, emit_col_reg} + (COL_W + 1)'(HALF);
    assign rr = (er_ext > {1'b0, geom.hm1}) ? geom.hm1 : er_ext[ROW_W-1:0];
    assign cc = (ec_ext > {1'b0, geom.wm1}) ? geom.wm1 : ec_ext[COL_W-1:0];
    assign out_ready = done_next || (in_row_next > rr) ||
                       (in_row_next == rr && in_col_next > cc);
    assign emit = try_out && out_ready;
    assign last = (emit_row_reg == geom.hm1) && (emit_col_reg == geom.wm1);

    // Line slot of each kernel row, with rows clamped into the frame.
    always_comb
    begin
        int t;
        for (int a = 0; a < KERNEL_SIZE; a++)
        begin
            t = int'(emit_row_reg) + a - HALF;
            if (t < 0)
                sel[a] = '0;
            else if (t > int'(geom.hm1))
                sel[a] = slot_wrap(emit_slot_reg, int'(geom.hm1) - int'(emit_row_reg));
            else
                sel[a] = slot_wrap(emit_slot_reg, a - HALF);
        end
    end

    // Output position advance.
    always_comb
    begin
        emit_row_next  = emit_row_reg;
        emit_col_next  = emit_col_reg;
        emit_slot_next = emit_slot_reg;
        if (emit && !last)
        begin
            if (emit_col_reg == geom.wm1)
            begin
                emit_col_next  = '0;
                emit_row_next  = emit_row_reg + 1'b1;
                emit_slot_next = slot_wrap(emit_slot_reg, 1);
            end
            else
            begin
                emit_col_next = emit_col_reg + 1'b1;
            end
        end
    end

    // Command for the back end.
    always_comb
    begin
        push_job.wr_en    = store;
        push_job.wr_slot  = in_slot_reg;
        push_job.wr_col   = in_col_reg;
        push_job.pixel    = item.pixel;
        push_job.coef_en  = (item.kind == KIND_COEF) && (int'(item.coef_index) < TAPS);
        push_job.coef_idx = item.coef_index;
        push_job.coef_val = item.coef_value;
        push_job.emit     = emit;
        push_job.row      = emit_row_reg;
        push_job.col      = emit_col_reg;
        push_job.last     = last;
        push_job.sel      = sel;
    end

    assign push_valid = item.valid && (push_job.wr_en || push_job.coef_en || push_job.emit);

    // Registers and frame positions.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= RESET_WIDTH;
            height_reg    <= RESET_HEIGHT;
            in_row_reg    <= '0;
            in_col_reg    <= '0;
            in_slot_reg   <= '0;
            done_reg      <= 1'b0;
            emit_row_reg  <= '0;
            emit_col_reg  <= '0;
            emit_slot_reg <= '0;
        end
        else if (cfg_hit)
        begin
            if (cfg.index == REG_WIDTH)
                width_reg <= cfg.data;
            else
                height_reg <= cfg.data;
            in_row_reg    <= '0;
            in_col_reg    <= '0;
            in_slot_reg   <= '0;
            done_reg      <= 1'b0;
            emit_row_reg  <= '0;
            emit_col_reg  <= '0;
            emit_slot_reg <= '0;
        end
        else if (accept)
        begin
            if (emit && last)
            begin
                in_row_reg    <= '0;
                in_col_reg    <= '0;
                in_slot_reg   <= '0;
                done_reg      <= 1'b0;
                emit_row_reg  <= '0;
                emit_col_reg  <= '0;
                emit_slot_reg <= '0;
            end
            else
            begin
                in_row_reg    <= in_row_next;
                in_col_reg    <= in_col_next;
                in_slot_reg   <= in_slot_next;
                done_reg      <= done_next;
                emit_row_reg  <= emit_row_next;
                emit_col_reg  <= emit_col_next;
                emit_slot_reg <= emit_slot_next;
            end
        end
    end

endmodule

// File: src/c2rb_queue.sv
// Short command queue that decouples the front end from the back end.
module c2rb_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  c2rb_pkg::job_t push_job,
    output logic           head_valid,
    output c2rb_pkg::job_t head_job,
    input  logic           pop
);
    import c2rb_pkg::*;

    job_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && head_valid;

    // Pointer and fill level updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

endmodule

// File: src/c2rb_back.sv
// Back end: line store, sliding window, coefficient bank and multiply-add pipeline.
module c2rb_back (
    input  logic            clk,
    input  logic            rst_n,
    input  c2rb_pkg::geom_t geom,
    input  logic            head_valid,
    input  c2rb_pkg::job_t  head_job,
    output logic            pop,
    output logic            adv,
    c2rb_out_if.source      filtered
);
    import c2rb_pkg::*;

    typedef struct packed {
        logic                     rd;
        logic                     bcast;
        logic                     fin;
        logic                     last;
        logic [ROW_W-1:0]         row;
        logic [COL_W-1:0]         col;
        slot_t [KERNEL_SIZE-1:0]  sel;
        logic                     coef_en;
        logic [CIDX_W-1:0]        coef_idx;
        logic signed [COEF_W-1:0] coef_val;
    } read_t;

    typedef struct packed {
        logic                     emit;
        logic                     last;
        logic [ROW_W-1:0]         row;
        logic [COL_W-1:0]         col;
        logic                     coef_en;
        logic [CIDX_W-1:0]        coef_idx;
        logic signed [COEF_W-1:0] coef_val;
    } win_t;

    typedef struct packed {
        logic             emit;
        logic             last;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } tag_t;

    logic [STEP_W-1:0] step_reg;
    logic              multi;
    logic              fin;
    logic              re;
    logic              we;
    logic [COL_W:0]    addr_ext;
    logic [COL_W-1:0]  raddr;

    logic signed [PIX_W-1:0]    rd_q [LINE_ROWS];
    logic signed [PIX_W-1:0]    win_reg [KERNEL_SIZE][KERNEL_SIZE];
    logic signed [COEF_W-1:0]   coef_reg [TAPS];
    logic signed [PROD_W-1:0]   prod_reg [TAPS];
    logic signed [ROWSUM_W-1:0] rs_c [KERNEL_SIZE];
    logic signed [ROWSUM_W-1:0] rs_reg [KERNEL_SIZE];
    logic signed [ACC_W-1:0]    acc_c;
    logic signed [ACC_W-1:0]    acc_reg;

    read_t s_rd_reg;
    win_t  s_win_reg;
    tag_t  s_prod_reg;
    tag_t  s_rs_reg;
    tag_t  s_acc_reg;

    logic                    out_v_reg;
    logic signed [RES_W-1:0] out_res_reg;
    logic [POS_W-1:0]        out_row_reg;
    logic [POS_W-1:0]        out_col_reg;
    logic                    out_last_reg;

    // The whole pipeline moves unless a result waits at the output.
    assign adv = !out_v_reg || filtered.ready;

    // An output at column zero reads columns zero to HALF to fill the window.
    assign multi = head_job.emit && (head_job.col == '0);
    assign fin   = !multi || (step_reg == STEP_W'(HALF));
    assign pop   = head_valid && adv && fin;
    assign re    = head_valid && head_job.emit;
    assign we    = head_valid && head_job.wr_en && (step_reg == '0);

    assign addr_ext = multi ? (COL_W + 1)'(step_reg)
                            : {1'b0, head_job.col} + (COL_W + 1)'(HALF);
    assign raddr = (addr_ext > {1'b0, geom.wm1}) ? geom.wm1 : addr_ext[COL_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= '0;
        else if (head_valid && adv)
            step_reg <= fin ? '0 : step_reg + 1'b1;
    end

    // Line store: one bank per line slot, all read at the same column.
    for (genvar g = 0; g < LINE_ROWS; g++)
    begin : g_bank
        logic signed [PIX_W-1:0] mem [MAX_WIDTH];
        logic signed [PIX_W-1:0] q_reg;
        logic                    hit;

        assign hit = we && (head_job.wr_slot == slot_t'(g));

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (hit)
                    mem[head_job.wr_col] <= head_job.pixel;
                if (re)
                begin
                    if (hit && head_job.wr_col == raddr)
                        q_reg <= head_job.pixel;
                    else
                        q_reg <= mem[raddr];
                end
            end
        end

        assign rd_q[g] = q_reg;
    end

    // Stage control flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_rd_reg   <= '0;
            s_win_reg  <= '0;
            s_prod_reg <= '0;
            s_rs_reg   <= '0;
            s_acc_reg  <= '0;
            out_v_reg  <= 1'b0;
        end
        else if (adv)
        begin
            s_rd_reg.rd       <= re;
            s_rd_reg.bcast    <= multi && (step_reg == '0);
            s_rd_reg.fin      <= fin;
            s_rd_reg.last     <= head_job.last;
            s_rd_reg.row      <= head_job.row;
            s_rd_reg.col      <= head_job.col;
            s_rd_reg.sel      <= head_job.sel;
            s_rd_reg.coef_en  <= head_valid && head_job.coef_en;
            s_rd_reg.coef_idx <= head_job.coef_idx;
            s_rd_reg.coef_val <= head_job.coef_val;

            s_win_reg.emit     <= s_rd_reg.rd && s_rd_reg.fin;
            s_win_reg.last     <= s_rd_reg.last;
            s_win_reg.row      <= s_rd_reg.row;
            s_win_reg.col      <= s_rd_reg.col;
            s_win_reg.coef_en  <= s_rd_reg.coef_en;
            s_win_reg.coef_idx <= s_rd_reg.coef_idx;
            s_win_reg.coef_val <= s_rd_reg.coef_val;

            s_prod_reg.emit <= s_win_reg.emit;
            s_prod_reg.last <= s_win_reg.last;
            s_prod_reg.row  <= s_win_reg.row;
            s_prod_reg.col  <= s_win_reg.col;

            s_rs_reg  <= s_prod_reg;
            s_acc_reg <= s_rs_reg;
            out_v_reg <= s_acc_reg.emit;
        end
    end

    // Sliding window: a row start fills every column, later reads shift in at the right.
    always_ff @(posedge clk)
    begin
        if (adv && s_rd_reg.rd)
        begin
            for (int a = 0; a < KERNEL_SIZE; a++)
            begin
                for (int b = 0; b < KERNEL_SIZE; b++)
                begin
                    if (s_rd_reg.bcast || b == KERNEL_SIZE - 1)
                        win_reg[a][b] <= rd_q[s_rd_reg.sel[a]];
                    else
                        win_reg[a][b] <= win_reg[a][b + 1];
                end
            end
        end
    end

    // Coefficient loads take effect in order with the outputs around them.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int t = 0; t < TAPS; t++)
                coef_reg[t] <= '0;
        end
        else if (adv && s_win_reg.coef_en)
        begin
            for (int t = 0; t < TAPS; t++)
            begin
                if (s_win_reg.coef_idx == CIDX_W'(t))
                    coef_reg[t] <= s_win_reg.coef_val;
            end
        end
    end

    // Row sums and total of the products.
    always_comb
    begin
        for (int a = 0; a < KERNEL_SIZE; a++)
        begin
            rs_c[a] = '0;
            for (int b = 0; b < KERNEL_SIZE; b++)
                rs_c[a] = rs_c[a] + ROWSUM_W'(prod_reg[a * KERNEL_SIZE + b]);
        end
        acc_c = '0;
        for (int a = 0; a < KERNEL_SIZE; a++)
            acc_c = acc_c + ACC_W'(rs_reg[a]);
    end

    // Products, row sums, total and output register.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int a = 0; a < KERNEL_SIZE; a++)
            begin
                for (int b = 0; b < KERNEL_SIZE; b++)
                    prod_reg[a * KERNEL_SIZE + b] <= PROD_W'(win_reg[a][b]) *
                                                     PROD_W'(coef_reg[a * KERNEL_SIZE + b]);
                rs_reg[a] <= rs_c[a];
            end
            acc_reg      <= acc_c;
            out_res_reg  <= acc_reg[RES_W-1:0];
            out_row_reg  <= POS_W'(s_acc_reg.row);
            out_col_reg  <= POS_W'(s_acc_reg.col);
            out_last_reg <= s_acc_reg.last;
        end
    end

    assign filtered.valid      = out_v_reg;
    assign filtered.result     = out_res_reg;
    assign filtered.out_row    = out_row_reg;
    assign filtered.out_col    = out_col_reg;
    assign filtered.frame_last = out_last_reg;

endmodule

// File: src/conv2d_replicate_border.sv
// A result passes the command queue, line store read, window, products, row sums, total
// and output register; an output at column zero holds the line store read port while it
// reads columns zero to KERNEL_SIZE/2 to fill the window. Throughput: one item per cycle
// while the command queue has room. Reset (rst_n, asynchronous, active low) clears positions
// and coefficients and sets the frame to 640 by 480; the line store is not cleared.
module conv2d_replicate_border (
    input logic         clk,
    input logic         rst_n,
    c2rb_in_if.sink     item,
    c2rb_out_if.source  filtered,
    c2rb_cfg_if.sink    cfg
);
    import c2rb_pkg::*;

    logic  push_valid;
    logic  push_ready;
    job_t  push_job;
    logic  head_valid;
    job_t  head_job;
    logic  pop;
    logic  adv;
    geom_t geom;

    // Front end: classification and frame positions.
    c2rb_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .cfg        (cfg),
        .push_valid (push_valid),
        .push_job   (push_job),
        .push_ready (push_ready),
        .geom       (geom)
    );

    // Command queue.
    c2rb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop)
    );

    // Back end: storage and arithmetic.
    c2rb_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .geom       (geom),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .adv        (adv),
        .filtered   (filtered)
    );

`ifndef SYNTHESIS
    // A command that needs a single read leaves the queue as soon as the pipeline moves.
    a_single_pop: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid && adv && !(head_job.emit && head_job.col == '0) |-> pop)
        else $error("single-step command was not popped");

    // The queue is popped only with a valid head while the pipeline moves.
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid && adv)
        else $error("queue popped without a valid head or while stalled");

    // A filling row start stays at the head for its whole read sequence.
    a_fill_hold: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid && adv && !pop |=> head_valid && head_job.emit && head_job.col == '0)
        else $error("row start fill lost its command");
`endif

endmodule

// File: tb/tb_conv2d_replicate_border.sv
// Self-checking testbench for the replicate-border 2D convolution block.
`timescale 1ns / 100ps

module tb_conv2d_replicate_border;
    import c2rb_pkg::*;

    // Packed description of one input transaction.
    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic [CIDX_W-1:0]        coef_index;
        logic signed [COEF_W-1:0] coef_value;
        logic signed [PIX_W-1:0]  pixel;
    } item_t;

    // One predicted output pixel.
    typedef struct packed {
        logic signed [RES_W-1:0] result;
        logic [POS_W-1:0]        out_row;
        logic [POS_W-1:0]        out_col;
        logic                    frame_last;
    } pix_out_t;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    logic clk;
    logic rst_n;

    c2rb_in_if  item_if();
    c2rb_out_if out_if();
    c2rb_cfg_if cfg_if();

    conv2d_replicate_border uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item_if.sink),
        .filtered (out_if.source),
        .cfg      (cfg_if.sink)
    );

    // Predictor state: a mirror of the block's frame geometry and storage.
    logic signed [COEF_W-1:0] kern [TAPS];
    logic signed [PIX_W-1:0]  lines [LINE_ROWS][MAX_WIDTH];
    int  pos_row, pos_col, out_r, out_c;
    bit  frame_in_done;
    int  width_reg, height_reg;

    item_t    pending_items [$];
    pix_out_t expected_pixels [$];

    int  send_idle_pct;
    int  recv_stall_pct;
    int  errors;
    int  idle_cycles;

    function automatic int eff_w();
        if (width_reg == 0) return 1;
        if (width_reg > MAX_WIDTH) return MAX_WIDTH;
        return width_reg;
    endfunction

    function automatic int eff_h();
        if (height_reg == 0) return 1;
        if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
        return height_reg;
    endfunction

    function automatic int clampi(int v, int n);
        if (v < 0) return 0;
        if (v > n - 1) return n - 1;
        return v;
    endfunction

    function automatic void restart_frame();
        pos_row = 0;
        pos_col = 0;
        out_r = 0;
        out_c = 0;
        frame_in_done = 0;
    endfunction

    // Append one item to the stimulus queue.
    function automatic void add_item(item_t it);
        pending_items.insert(pending_items.size(), it);
    endfunction

    // Emit the next output pixel if its window is complete.
    function automatic void emit_if_ready();
        int w;
        int h;
        int rr;
        int cc;
        int r;
        int c;
        longint acc;
        pix_out_t p;
        w = eff_w();
        h = eff_h();
        rr = clampi(out_r + KERNEL_SIZE - 1 - HALF, h);
        cc = clampi(out_c + KERNEL_SIZE - 1 - HALF, w);
        if (!(frame_in_done || pos_row > rr || (pos_row == rr && pos_col > cc))) return;
        acc = 0;
        for (int a = 0; a < KERNEL_SIZE; a++) begin
            r = clampi(out_r - HALF + a, h);
            for (int b = 0; b < KERNEL_SIZE; b++) begin
                c = clampi(out_c - HALF + b, w);
                acc += longint'(lines[r % LINE_ROWS][c]) * longint'(kern[a * KERNEL_SIZE + b]);
            end
        end
        p.result = acc[RES_W-1:0];
        p.out_row = out_r[POS_W-1:0];
        p.out_col = out_c[POS_W-1:0];
        p.frame_last = (out_r == h - 1) && (out_c == w - 1);
        expected_pixels.insert(expected_pixels.size(), p);
        if (p.frame_last) begin
            restart_frame();
        end
        else begin
            out_c++;
            if (out_c >= w) begin
                out_c = 0;
                out_r++;
            end
        end
    endfunction

    function automatic void predict_item(item_t it);
        case (it.kind)
            KIND_COEF:
            begin
                if (it.coef_index < TAPS) kern[it.coef_index] = it.coef_value;
            end
            KIND_PIXEL:
            begin
                if (!frame_in_done) begin
                    lines[pos_row % LINE_ROWS][pos_col] = it.pixel;
                    pos_col++;
                    if (pos_col >= eff_w()) begin
                        pos_col = 0;
                        pos_row++;
                        if (pos_row >= eff_h()) frame_in_done = 1;
                    end
                end
                emit_if_ready();
            end
            KIND_DRAIN:
            begin
                emit_if_ready();
            end
            default:
            begin
            end
        endcase
    endfunction

    // Clock generation.
    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Input driver: presents queued items, idling at random.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            item_if.valid <= 0;
            item_if.kind <= '0;
            item_if.coef_index <= '0;
            item_if.coef_value <= '0;
            item_if.pixel <= '0;
        end
        else begin
            if (item_if.valid && item_if.ready) begin
                predict_item({item_if.kind, item_if.coef_index, item_if.coef_value,
                              item_if.pixel});
            end
            if (!item_if.valid || item_if.ready) begin
                if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    item_t it;
                    it = pending_items.pop_front();
                    item_if.valid <= 1;
                    item_if.kind <= it.kind;
                    item_if.coef_index <= it.coef_index;
                    item_if.coef_value <= it.coef_value;
                    item_if.pixel <= it.pixel;
                end
                else begin
                    item_if.valid <= 0;
                end
            end
        end
    end

    // Output monitor: random back-pressure and comparison with predictions.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_if.ready <= 0;
            idle_cycles <= 0;
        end
        else begin
            if (out_if.valid && out_if.ready) begin
                if (expected_pixels.size() == 0) begin
                    $display("%0t: unexpected output expected none actual %0d (%0d,%0d) last %0b",
                             $time, out_if.result, out_if.out_row, out_if.out_col,
                             out_if.frame_last);
                    errors++;
                end
                else begin
                    pix_out_t e;
                    e = expected_pixels.pop_front();
                    if (out_if.result !== e.result) begin
                        $display("%0t: result mismatch expected %0d actual %0d",
                                 $time, e.result, out_if.result);
                        errors++;
                    end
                    if (out_if.out_row !== e.out_row) begin
                        $display("%0t: out_row mismatch expected %0d actual %0d",
                                 $time, e.out_row, out_if.out_row);
                        errors++;
                    end
                    if (out_if.out_col !== e.out_col) begin
                        $display("%0t: out_col mismatch expected %0d actual %0d",
                                 $time, e.out_col, out_if.out_col);
                        errors++;
                    end
                    if (out_if.frame_last !== e.frame_last) begin
                        $display("%0t: frame_last mismatch expected %0b actual %0b",
                                 $time, e.frame_last, out_if.frame_last);
                        errors++;
                    end
                end
            end
            out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
            if ((item_if.valid && item_if.ready) || (out_if.valid && out_if.ready)
                || (cfg_if.valid && cfg_if.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Watchdog on stalled progress.
    always @(posedge clk)
    begin
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Write one register while the block is idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        @(posedge clk);
        cfg_if.valid <= 1;
        cfg_if.index <= idx;
        cfg_if.data <= val[DIM_W-1:0];
        do @(posedge clk); while (!cfg_if.ready);
        if (idx == REG_WIDTH) width_reg = val;
        else height_reg = val;
        restart_frame();
        cfg_if.valid <= 0;
    endtask

    task automatic wait_quiet();
        while (pending_items.size() > 0 || item_if.valid || expected_pixels.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic item_t mk(logic [KIND_W-1:0] k, int idx, int cv, int px);
        item_t it;
        it.kind = k;
        it.coef_index = idx[CIDX_W-1:0];
        it.coef_value = cv[COEF_W-1:0];
        it.pixel = px[PIX_W-1:0];
        return it;
    endfunction

    function automatic int rnd16();
        case ($urandom_range(3))
            0: return 32767;
            1: return -32768;
            default: return int'($urandom_range(65535)) - 32768;
        endcase
    endfunction

    // Queue one complete frame of pixels with drains, plus occasional noise.
    task automatic queue_frame(input int w, input int h, input bit noisy);
        for (int i = 0; i < w * h; i++) begin
            if (noisy && $urandom_range(19) == 0)
                add_item(mk(KIND_COEF, $urandom_range(31), rnd16(), 0));
            if (noisy && $urandom_range(29) == 0)
                add_item(mk(KIND_UNUSED, $urandom_range(31), rnd16(), rnd16()));
            if (noisy && $urandom_range(29) == 0)
                add_item(mk(KIND_DRAIN, 0, 0, 0));
            add_item(mk(KIND_PIXEL, $urandom_range(31), rnd16(), rnd16()));
        end
        // Drains, and sometimes pixels acting as drains, flush the bottom border.
        for (int i = 0; i < 3 * w + 8; i++)
            add_item(mk($urandom_range(1) ? KIND_DRAIN : KIND_PIXEL, 0, 0, rnd16()));
    endtask

    task automatic load_kernel(input int mode);
        for (int i = 0; i < TAPS; i++)
            add_item(mk(KIND_COEF, i,
                mode == 0 ? 32767 : mode == 1 ? -32768 : rnd16(), 0));
    endtask

    // Stimulus sequence.
    initial
    begin
        int sizes [8][2];
        errors = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        width_reg = RESET_WIDTH;
        height_reg = RESET_HEIGHT;
        for (int i = 0; i < TAPS; i++) kern[i] = '0;
        restart_frame();
        cfg_if.valid = 0;
        cfg_if.index = REG_WIDTH;
        cfg_if.data = '0;
        rst_n = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1;

        // Directed: zero dimensions act as one, then extremes of pixels and coefficients.
        write_reg(REG_WIDTH, 0);
        write_reg(REG_HEIGHT, 0);
        add_item(mk(KIND_DRAIN, 0, 0, 0));
        add_item(mk(KIND_COEF, 31, 1234, 0));
        load_kernel(1);
        add_item(mk(KIND_PIXEL, 0, 0, -32768));
        add_item(mk(KIND_PIXEL, 0, 0, 7));
        add_item(mk(KIND_DRAIN, 0, 0, 0));
        wait_quiet();
        write_reg(REG_WIDTH, 3);
        write_reg(REG_HEIGHT, 2);
        load_kernel(0);
        add_item(mk(KIND_UNUSED, 31, -1, -1));
        for (int i = 0; i < 6; i++)
            add_item(mk(KIND_PIXEL, 0, 0, i[0] ? 32767 : -32768));
        for (int i = 0; i < 8; i++) add_item(mk(KIND_DRAIN, 0, 0, 0));
        wait_quiet();

        // Large register values clamp to the maximum; the start of a one-row full-width frame.
        write_reg(REG_HEIGHT, 8191);
        write_reg(REG_WIDTH, 8191);
        write_reg(REG_HEIGHT, 1);
        load_kernel(2);
        for (int i = 0; i < 200; i++) add_item(mk(KIND_PIXEL, 0, 0, rnd16()));
        wait_quiet();
        write_reg(REG_WIDTH, 1);
        write_reg(REG_HEIGHT, 5000);
        wait_quiet();

        // Random phases over several sizes and idling patterns.
        sizes = '{'{1, 1}, '{2, 7}, '{5, 5}, '{7, 3}, '{1, 9}, '{11, 4}, '{6, 6}, '{4, 8}};
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
                default: begin send_idle_pct = 25; recv_stall_pct = 25; end
            endcase
            for (int s = 2 * ph; s < 2 * ph + 2; s++) begin
                write_reg(REG_WIDTH, sizes[s][0]);
                write_reg(REG_HEIGHT, sizes[s][1]);
                load_kernel(2);
                queue_frame(sizes[s][0], sizes[s][1], 1);
                queue_frame(sizes[s][0], sizes[s][1], 1);
                wait_quiet();
            end
        end

        if (errors == 0) begin
            $display("RESULT: OK");
        end
        else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
